[design/ljpe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljpe_pkg
// Shared sizes, codes, state type and saturating helpers of the
// Lennard-Jones pair energy engine.
// ----------------------------------------------------------------------------
package ljpe_pkg;

	localparam int MAX_PARTICLES = 256;
	localparam int NUM_BINS      = 32;

	localparam int ADDR_W    = $clog2(MAX_PARTICLES);
	localparam int CNT_W     = ADDR_W + 1;
	localparam int BIN_AW    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

	localparam int OP_W      = 2;
	localparam int INDEX_W   = 8;
	localparam int POS_W     = 32;
	localparam int WORD_W    = 3 * POS_W;
	localparam int KIND_W    = 2;
	localparam int BIN_NUM_W = 6;
	localparam int VALUE_W   = 64;
	localparam int HIST_W    = 17;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 40;
	localparam int COUNT_W   = 9;
	localparam int LEN_W     = 31;
	localparam int CUT_W     = 40;

	localparam logic [HIST_W-1:0]  HIST_MAX = '1;
	localparam logic [63:0]        CAP63    = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] SMAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] SMIN     = 64'sh8000_0000_0000_0000;

	localparam logic [COUNT_W-1:0] COUNT_RST  = 9'd108;
	localparam logic [LEN_W-1:0]   BOX_RST    = 31'd167772160;
	localparam logic [CUT_W-1:0]   CUTOFF_RST = 40'd104857600;
	localparam logic [LEN_W-1:0]   BW_RST     = 31'd838861;

	typedef enum logic [OP_W-1:0] {
		OP_STORE   = 2'd0,
		OP_TRIAL   = 2'd1,
		OP_MEASURE = 2'd2
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_TRIAL  = 2'd0,
		KIND_TOTAL  = 2'd1,
		KIND_VIRIAL = 2'd2,
		KIND_BIN    = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COUNT     = 2'd0,
		CFG_BOX       = 2'd1,
		CFG_CUTOFF    = 2'd2,
		CFG_BIN_WIDTH = 2'd3
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CLEAR, ST_TSEL, ST_ISEL, ST_ILOAD, ST_READ, ST_DIFF, ST_DIV,
		ST_ROUND, ST_SQ, ST_SQACC, ST_CUT, ST_INV, ST_MUL, ST_ACC, ST_HIST,
		ST_SQRT, ST_HSQ, ST_HCHK, ST_HRD, ST_NEXT, ST_TEMIT, ST_EEMIT, ST_WEMIT,
		ST_BRD, ST_BOUT
	} state_t;

	function automatic logic [63:0] cap_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, CAP63}) ? CAP63 : s[63:0];
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? SMIN : SMAX;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] sat_mul4(input logic signed [63:0] a);
		if (a[63:61] == 3'b000 || a[63:61] == 3'b111)
			return {a[61:0], 2'b00};
		return a[63] ? SMIN : SMAX;
	endfunction

	function automatic logic signed [63:0] sat_mul16(input logic signed [63:0] a);
		if (a[63:59] == 5'b00000 || a[63:59] == 5'b11111)
			return {a[59:0], 4'b0000};
		return a[63] ? SMIN : SMAX;
	endfunction

endpackage

[design/ljpe_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljpe_ram
// Generic single-clock RAM, one write port, one read port with registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module ljpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

[design/lennard_jones_pair_energy_engine_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lennard_jones_pair_energy_engine_unit
// Particle positions in a position RAM; trial energy, full-pair energy,
// virial and radial histogram computed one pair at a time.
//
//  channel  direction  handshake              payload
//  in       to block   in_valid / in_stall    operation, particle_index, pos_x/y/z
//  out      from block out_valid / out_stall  result_kind, bin_number, value, last
//  cfg      to block   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A pair is worked through the shared 33-step divider used for folding and
// the 81-step reciprocal, which a pair outside the cutoff skips; a measure
// pair adds the histogram update. A measure first clears the histogram RAM.
// Reset is asynchronous; RAM contents are not reset. A stalled output holds
// the sequencer at its next result; one finished result waits in the
// output register while the next item is taken.
// ----------------------------------------------------------------------------
module lennard_jones_pair_energy_engine_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [ljpe_pkg::OP_W-1:0]            operation,
	input  logic [ljpe_pkg::INDEX_W-1:0]         particle_index,
	input  logic signed [ljpe_pkg::POS_W-1:0]    pos_x,
	input  logic signed [ljpe_pkg::POS_W-1:0]    pos_y,
	input  logic signed [ljpe_pkg::POS_W-1:0]    pos_z,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [ljpe_pkg::KIND_W-1:0]          result_kind,
	output logic [ljpe_pkg::BIN_NUM_W-1:0]       bin_number,
	output logic signed [ljpe_pkg::VALUE_W-1:0]  value,
	output logic                                 last,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ljpe_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ljpe_pkg::CFG_W-1:0]           cfg_data
);

	import ljpe_pkg::*;

	state_t state_q, state_d;

	logic [COUNT_W-1:0] count_q;
	logic [LEN_W-1:0]   box_q;
	logic [CUT_W-1:0]   cutoff_q;
	logic [LEN_W-1:0]   bw_q;

	logic               in_take;
	logic [CNT_W-1:0]   n_clamp;
	logic [CNT_W-1:0]   n_q, bidx_q, i_q;
	logic               measure_q, hist_phase_q;
	logic [1:0]         comp_q;
	logic [5:0]         div_cnt_q;
	logic [6:0]         inv_cnt_q;
	logic [4:0]         sq_cnt_q;
	logic [2:0]         mq_ph_q;
	logic [1:0]         mq_k_q;
	logic [BIN_AW-1:0]  bin_q;

	logic signed [POS_W-1:0] ax_q, ay_q, az_q;
	logic [INDEX_W-1:0]      ip_q;
	logic [LEN_W-1:0]        mag_q;
	logic [32:0]             div_num_q, div_quo_q;
	logic [LEN_W-1:0]        div_rem_q;
	logic [63:0]             r2_q, inv_rem_q, inv_q, i2_q, i6_q, ma_q, mb_q, s_q, prod_q;
	logic [63:0]             sq_v_q, sq_res_q, sq_bit_q;
	logic signed [63:0]      e_acc_q, w_acc_q;

	logic               pos_wr_en, pos_rd_en;
	logic [ADDR_W-1:0]  pos_rd_addr;
	logic [WORD_W-1:0]  pos_rd_data;
	logic               hist_wr_en, hist_rd_en;
	logic [BIN_AW-1:0]  hist_wr_addr, hist_rd_addr;
	logic [HIST_W-1:0]  hist_wr_data, hist_rd_data;

	logic               out_valid_q, out_last_q, out_load, out_last_d;
	kind_t              out_kind_q, out_kind_d;
	logic [BIN_NUM_W-1:0] out_bin_q, out_bin_d;
	logic signed [63:0] out_value_q, out_value_d;

	logic signed [POS_W-1:0] comp_a, comp_b;
	logic [32:0]        diff, diff_mag;
	logic [LEN_W-1:0]   clamp_mag, div_divisor, div_rem_d, fold_mag;
	logic [31:0]        div_remx, rem2;
	logic               div_ge, round_up;
	logic [64:0]        inv_remx;
	logic               inv_ge;
	logic [63:0]        inv_rem_d, inv_q_d, i2_d;
	logic [31:0]        mul_a, mul_b;
	logic [63:0]        s_first, s_add, s_lo;
	logic [63:0]        sq_t, sq_res_d;
	logic               sq_ge;
	logic signed [63:0] ev, wv;
	logic               hist_drop;
	logic [HIST_W:0]    hist_sum;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign n_clamp   = (int'(count_q) > MAX_PARTICLES) ? CNT_W'(MAX_PARTICLES)
		: CNT_W'(count_q);

	assign out_valid   = out_valid_q;
	assign result_kind = out_kind_q;
	assign bin_number  = out_bin_q;
	assign value       = out_value_q;
	assign last        = out_last_q;

	ljpe_ram #(.WIDTH(WORD_W), .DEPTH(MAX_PARTICLES)) u_pos_ram (
		.clk     (clk),
		.wr_en   (pos_wr_en),
		.wr_addr (ADDR_W'(particle_index)),
		.wr_data ({pos_x, pos_y, pos_z}),
		.rd_en   (pos_rd_en),
		.rd_addr (pos_rd_addr),
		.rd_data (pos_rd_data)
	);

	ljpe_ram #(.WIDTH(HIST_W), .DEPTH(NUM_BINS)) u_hist_ram (
		.clk     (clk),
		.wr_en   (hist_wr_en),
		.wr_addr (hist_wr_addr),
		.wr_data (hist_wr_data),
		.rd_en   (hist_rd_en),
		.rd_addr (hist_rd_addr),
		.rd_data (hist_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= COUNT_RST;
			box_q    <= BOX_RST;
			cutoff_q <= CUTOFF_RST;
			bw_q     <= BW_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_COUNT:     count_q  <= cfg_data[COUNT_W-1:0];
				CFG_BOX:       box_q    <= cfg_data[LEN_W-1:0];
				CFG_CUTOFF:    cutoff_q <= cfg_data[CUT_W-1:0];
				CFG_BIN_WIDTH: bw_q     <= cfg_data[LEN_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (comp_q)
			2'd0: begin
				comp_a = ax_q;
				comp_b = pos_rd_data[3*POS_W-1:2*POS_W];
			end
			2'd1: begin
				comp_a = ay_q;
				comp_b = pos_rd_data[2*POS_W-1:POS_W];
			end
			default: begin
				comp_a = az_q;
				comp_b = pos_rd_data[POS_W-1:0];
			end
		endcase
	end

	assign diff      = {comp_a[31], comp_a} - {comp_b[31], comp_b};
	assign diff_mag  = diff[32] ? (33'd0 - diff) : diff;
	assign clamp_mag = (diff_mag[32:31] != 2'b00) ? '1 : diff_mag[30:0];

	assign div_divisor = hist_phase_q ? bw_q : box_q;
	assign div_remx    = {div_rem_q, div_num_q[32]};
	assign div_ge      = div_remx >= {1'b0, div_divisor};
	assign div_rem_d   = div_ge ? LEN_W'(div_remx - {1'b0, div_divisor}) : div_remx[30:0];

	assign rem2     = {div_rem_q, 1'b0};
	assign round_up = (rem2 > {1'b0, box_q}) || (rem2 == {1'b0, box_q} && div_quo_q[0]);
	assign fold_mag = round_up ? (box_q - div_rem_q) : div_rem_q;

	assign inv_remx  = {inv_rem_q, inv_cnt_q == 7'd0};
	assign inv_ge    = inv_remx >= {1'b0, r2_q};
	assign inv_rem_d = inv_ge ? 64'(inv_remx - {1'b0, r2_q}) : inv_remx[63:0];
	assign inv_q_d   = {inv_q[62:0], inv_ge};
	assign i2_d      = inv_q_d[63] ? CAP63 : inv_q_d;

	assign s_first = (prod_q[63:31] != '0) ? CAP63 : {prod_q[31:0], 32'd0};
	assign s_add   = cap_add(s_q, prod_q);
	assign s_lo    = cap_add(s_q, {32'd0, prod_q[63:32]});

	assign sq_t     = sq_res_q + sq_bit_q;
	assign sq_ge    = sq_v_q >= sq_t;
	assign sq_res_d = sq_ge ? ((sq_res_q >> 1) + sq_bit_q) : (sq_res_q >> 1);

	assign ev = $signed(s_q) - $signed(i6_q);
	assign wv = $signed(s_q) - $signed(i6_q >> 1);

	assign hist_drop = (div_rem_q == '0 && prod_q == r2_q) || (div_quo_q >= 33'(NUM_BINS));
	assign hist_sum  = {1'b0, hist_rd_data} + (HIST_W+1)'(2);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SQ: begin
				mul_a = {1'b0, mag_q};
				mul_b = {1'b0, mag_q};
			end
			ST_HSQ: begin
				mul_a = sq_res_q[31:0];
				mul_b = sq_res_q[31:0];
			end
			ST_MUL: begin
				mul_a = (mq_ph_q <= 3'd1) ? ma_q[63:32] : ma_q[31:0];
				mul_b = (mq_ph_q == 3'd0 || mq_ph_q == 3'd2) ? mb_q[63:32] : mb_q[31:0];
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d      = state_q;
		pos_wr_en    = 1'b0;
		pos_rd_en    = 1'b0;
		pos_rd_addr  = bidx_q[ADDR_W-1:0];
		hist_wr_en   = 1'b0;
		hist_wr_addr = div_quo_q[BIN_AW-1:0];
		hist_wr_data = (hist_sum > {1'b0, HIST_MAX}) ? HIST_MAX : hist_sum[HIST_W-1:0];
		hist_rd_en   = 1'b0;
		hist_rd_addr = div_quo_q[BIN_AW-1:0];
		out_load     = 1'b0;
		out_kind_d   = KIND_TRIAL;
		out_bin_d    = '0;
		out_value_d  = '0;
		out_last_d   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					unique case (operation)
						OP_STORE:   pos_wr_en = int'(particle_index) < MAX_PARTICLES;
						OP_TRIAL:   state_d = ST_TSEL;
						OP_MEASURE: state_d = ST_CLEAR;
						default: ;
					endcase
				end
			end
			ST_CLEAR: begin
				hist_wr_en   = 1'b1;
				hist_wr_addr = bin_q;
				hist_wr_data = '0;
				if (int'(bin_q) == NUM_BINS - 1)
					state_d = ST_ISEL;
			end
			ST_TSEL: begin
				if (bidx_q >= n_q)
					state_d = ST_TEMIT;
				else if (int'(bidx_q) != int'(ip_q))
					state_d = ST_READ;
			end
			ST_ISEL: begin
				if (int'(i_q) + 1 >= int'(n_q)) begin
					state_d = ST_EEMIT;
				end else begin
					pos_rd_en   = 1'b1;
					pos_rd_addr = i_q[ADDR_W-1:0];
					state_d     = ST_ILOAD;
				end
			end
			ST_ILOAD: state_d = ST_READ;
			ST_READ: begin
				pos_rd_en = 1'b1;
				state_d   = ST_DIFF;
			end
			ST_DIFF:  state_d = (box_q == '0) ? ST_SQ : ST_DIV;
			ST_DIV: begin
				if (div_cnt_q == 6'd32)
					state_d = hist_phase_q ? ST_HSQ : ST_ROUND;
			end
			ST_ROUND: state_d = ST_SQ;
			ST_SQ:    state_d = ST_SQACC;
			ST_SQACC: state_d = (comp_q == 2'd2) ? ST_CUT : ST_DIFF;
			ST_CUT: begin
				if (r2_q[63:24] >= cutoff_q)
					state_d = measure_q ? ST_HIST : ST_NEXT;
				else if (r2_q[63:17] == '0)
					state_d = ST_MUL;
				else
					state_d = ST_INV;
			end
			ST_INV: begin
				if (inv_cnt_q == 7'd80)
					state_d = ST_MUL;
			end
			ST_MUL: begin
				if (mq_ph_q == 3'd4 && mq_k_q == 2'd2)
					state_d = ST_ACC;
			end
			ST_ACC:  state_d = measure_q ? ST_HIST : ST_NEXT;
			ST_HIST: state_d = (bw_q == '0) ? ST_NEXT : ST_SQRT;
			ST_SQRT: begin
				if (sq_cnt_q == 5'd31)
					state_d = ST_DIV;
			end
			ST_HSQ: state_d = ST_HCHK;
			ST_HCHK: begin
				if (hist_drop) begin
					state_d = ST_NEXT;
				end else begin
					hist_rd_en = 1'b1;
					state_d    = ST_HRD;
				end
			end
			ST_HRD: begin
				hist_wr_en = 1'b1;
				state_d    = ST_NEXT;
			end
			ST_NEXT: begin
				if (!measure_q)
					state_d = ST_TSEL;
				else if (int'(bidx_q) + 1 < int'(n_q))
					state_d = ST_READ;
				else
					state_d = ST_ISEL;
			end
			ST_TEMIT: begin
				out_kind_d  = KIND_TRIAL;
				out_value_d = sat_mul4(e_acc_q);
				out_last_d  = 1'b1;
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_EEMIT: begin
				out_kind_d  = KIND_TOTAL;
				out_value_d = sat_mul4(e_acc_q);
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_WEMIT;
				end
			end
			ST_WEMIT: begin
				out_kind_d  = KIND_VIRIAL;
				out_value_d = sat_mul16(w_acc_q);
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_BRD;
				end
			end
			ST_BRD: begin
				hist_rd_en   = 1'b1;
				hist_rd_addr = bin_q;
				state_d      = ST_BOUT;
			end
			ST_BOUT: begin
				out_kind_d  = KIND_BIN;
				out_bin_d   = BIN_NUM_W'(bin_q);
				out_value_d = VALUE_W'(hist_rd_data);
				out_last_d  = int'(bin_q) == NUM_BINS - 1;
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = out_last_d ? ST_IDLE : ST_BRD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			n_q          <= '0;
			bidx_q       <= '0;
			i_q          <= '0;
			measure_q    <= 1'b0;
			hist_phase_q <= 1'b0;
			comp_q       <= '0;
			div_cnt_q    <= '0;
			inv_cnt_q    <= '0;
			sq_cnt_q     <= '0;
			mq_ph_q      <= '0;
			mq_k_q       <= '0;
			bin_q        <= '0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_take && operation == OP_TRIAL) begin
						measure_q <= 1'b0;
						bidx_q    <= '0;
						n_q       <= n_clamp;
					end
					if (in_take && operation == OP_MEASURE) begin
						measure_q <= 1'b1;
						i_q       <= '0;
						n_q       <= n_clamp;
						bin_q     <= '0;
					end
				end
				ST_CLEAR: begin
					if (int'(bin_q) == NUM_BINS - 1)
						bin_q <= '0;
					else
						bin_q <= bin_q + 1'b1;
				end
				ST_TSEL: begin
					if (bidx_q < n_q && int'(bidx_q) == int'(ip_q))
						bidx_q <= bidx_q + 1'b1;
				end
				ST_ILOAD: bidx_q <= i_q + 1'b1;
				ST_READ:  comp_q <= '0;
				ST_DIFF: begin
					div_cnt_q    <= '0;
					hist_phase_q <= 1'b0;
				end
				ST_DIV:   div_cnt_q <= div_cnt_q + 1'b1;
				ST_SQACC: comp_q <= comp_q + 1'b1;
				ST_CUT: begin
					inv_cnt_q <= '0;
					mq_k_q    <= '0;
					mq_ph_q   <= '0;
				end
				ST_INV: inv_cnt_q <= inv_cnt_q + 1'b1;
				ST_MUL: begin
					if (mq_ph_q == 3'd4) begin
						mq_ph_q <= '0;
						mq_k_q  <= mq_k_q + 1'b1;
					end else begin
						mq_ph_q <= mq_ph_q + 1'b1;
					end
				end
				ST_HIST: sq_cnt_q <= '0;
				ST_SQRT: begin
					sq_cnt_q     <= sq_cnt_q + 1'b1;
					div_cnt_q    <= '0;
					hist_phase_q <= 1'b1;
				end
				ST_NEXT: begin
					if (!measure_q || int'(bidx_q) + 1 < int'(n_q))
						bidx_q <= bidx_q + 1'b1;
					else
						i_q <= i_q + 1'b1;
				end
				ST_EEMIT: bin_q <= '0;
				ST_BOUT: begin
					if (out_load && !out_last_d)
						bin_q <= bin_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (out_load) begin
			out_kind_q  <= out_kind_d;
			out_bin_q   <= out_bin_d;
			out_value_q <= out_value_d;
			out_last_q  <= out_last_d;
		end
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					ax_q    <= pos_x;
					ay_q    <= pos_y;
					az_q    <= pos_z;
					ip_q    <= particle_index;
					e_acc_q <= '0;
					w_acc_q <= '0;
				end
			end
			ST_ILOAD: begin
				ax_q <= pos_rd_data[3*POS_W-1:2*POS_W];
				ay_q <= pos_rd_data[2*POS_W-1:POS_W];
				az_q <= pos_rd_data[POS_W-1:0];
			end
			ST_READ: r2_q <= '0;
			ST_DIFF: begin
				mag_q     <= clamp_mag;
				div_num_q <= diff_mag;
				div_rem_q <= '0;
				div_quo_q <= '0;
			end
			ST_DIV: begin
				div_num_q <= {div_num_q[31:0], 1'b0};
				div_rem_q <= div_rem_d;
				div_quo_q <= {div_quo_q[31:0], div_ge};
			end
			ST_ROUND: mag_q <= fold_mag;
			ST_SQACC: r2_q <= r2_q + prod_q;
			ST_CUT: begin
				inv_rem_q <= '0;
				inv_q     <= '0;
				i2_q      <= CAP63;
				ma_q      <= CAP63;
				mb_q      <= CAP63;
			end
			ST_INV: begin
				inv_rem_q <= inv_rem_d;
				inv_q     <= inv_q_d;
				if (inv_cnt_q == 7'd80) begin
					i2_q <= i2_d;
					ma_q <= i2_d;
					mb_q <= i2_d;
				end
			end
			ST_MUL: begin
				unique case (mq_ph_q)
					3'd1: s_q <= s_first;
					3'd2, 3'd3: s_q <= s_add;
					3'd4: begin
						s_q <= s_lo;
						if (mq_k_q == 2'd0) begin
							ma_q <= s_lo;
							mb_q <= i2_q;
						end else if (mq_k_q == 2'd1) begin
							i6_q <= s_lo;
							ma_q <= s_lo;
							mb_q <= s_lo;
						end
					end
					default: ;
				endcase
			end
			ST_ACC: begin
				e_acc_q <= sat_add(e_acc_q, ev);
				w_acc_q <= sat_add(w_acc_q, wv);
			end
			ST_HIST: begin
				sq_v_q   <= r2_q;
				sq_res_q <= '0;
				sq_bit_q <= 64'h4000_0000_0000_0000;
			end
			ST_SQRT: begin
				if (sq_ge)
					sq_v_q <= sq_v_q - sq_t;
				sq_res_q  <= sq_res_d;
				sq_bit_q  <= sq_bit_q >> 2;
				div_num_q <= {1'b0, sq_res_d[31:0]};
				div_rem_q <= '0;
				div_quo_q <= '0;
			end
			default: ;
		endcase
	end

	a_hist_rmw_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HRD |-> $past(state_q) == ST_HCHK)
		else $error("histogram write without preceding read");

	a_recip_capped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && mq_k_q == 2'd0 && mq_ph_q == 3'd0) |-> !ma_q[63])
		else $error("reciprocal above signed range");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ && measure_q) |-> bidx_q > i_q)
		else $error("measure pair index not above outer index");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_last_d) |=> state_q == ST_IDLE)
		else $error("final result did not return to idle");

endmodule
